FILE: hw/rtl/differential_drive_mixer_assert.svh
// Assertion macros for the differential drive mixer.
`ifndef DIFFERENTIAL_DRIVE_MIXER_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_MIXER_ASSERT_SVH

// Clocked assertion, held off while reset is asserted.
`define DDM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

FILE: hw/rtl/ddm_pkg.sv
// Shared constants for the differential drive mixer.
`timescale 1ns / 1ps
package ddm_pkg;
	localparam int LIM_W   = 10;
	localparam int OUT_W   = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAG_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd2;

	localparam logic [LIM_W-1:0] MAG_LIMIT_RST  = 10'd180;
	localparam logic [LIM_W-1:0] FULL_SCALE_RST = 10'd250;
endpackage

FILE: hw/rtl/ddm_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module ddm_sqrt #(
	parameter int IN_W  = 22,
	parameter int TAG_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [IN_W-1:0]      in_rad,
	input  logic [TAG_W-1:0]     in_tag,
	output logic                 out_valid,
	output logic [IN_W/2-1:0]    out_root,
	output logic [TAG_W-1:0]     out_tag
);
	localparam int RT_W = IN_W / 2;

	logic              vld_sk  [0:RT_W];
	logic [IN_W-1:0]   rem_sk  [0:RT_W];
	logic [RT_W-1:0]   root_sk [0:RT_W];
	logic [TAG_W-1:0]  tag_sk  [0:RT_W];

	assign vld_sk[0]  = in_valid;
	assign rem_sk[0]  = in_rad;
	assign root_sk[0] = '0;
	assign tag_sk[0]  = in_tag;

	for (genvar g = 0; g < RT_W; g++) begin : g_stage
		localparam int BIT = RT_W - 1 - g;
		logic [IN_W+1:0] trial;
		logic            take;

		// (root + 2^k)^2 - root^2 = root*2^(k+1) + 2^(2k)
		assign trial = ((IN_W+2)'(root_sk[g]) << (BIT + 1)) + ((IN_W+2)'(1) << (2 * BIT));
		assign take  = {2'b00, rem_sk[g]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[g+1] <= 1'b0;
			end else if (en) begin
				vld_sk[g+1] <= vld_sk[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_sk[g+1] <= tag_sk[g];
				if (take) begin
					rem_sk[g+1]  <= rem_sk[g] - trial[IN_W-1:0];
					root_sk[g+1] <= root_sk[g] | (RT_W'(1) << BIT);
				end else begin
					rem_sk[g+1]  <= rem_sk[g];
					root_sk[g+1] <= root_sk[g];
				end
			end
		end
	end

	assign out_valid = vld_sk[RT_W];
	assign out_root  = root_sk[RT_W];
	assign out_tag   = tag_sk[RT_W];
endmodule

FILE: hw/rtl/ddm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module ddm_div #(
	parameter int NUM_W = 20,
	parameter int DEN_W = 10,
	parameter int Q_W   = 10,
	parameter int TAG_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [TAG_W-1:0]  in_tag,
	output logic              out_valid,
	output logic [Q_W-1:0]    out_quot,
	output logic [TAG_W-1:0]  out_tag
);
	// quotient must fit in Q_W bits
	localparam int SW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic              vld_sk [0:Q_W];
	logic [NUM_W-1:0]  rem_sk [0:Q_W];
	logic [DEN_W-1:0]  den_sk [0:Q_W];
	logic [Q_W-1:0]    quo_sk [0:Q_W];
	logic [TAG_W-1:0]  tag_sk [0:Q_W];

	assign vld_sk[0] = in_valid;
	assign rem_sk[0] = in_num;
	assign den_sk[0] = in_den;
	assign quo_sk[0] = '0;
	assign tag_sk[0] = in_tag;

	for (genvar g = 0; g < Q_W; g++) begin : g_stage
		localparam int BIT = Q_W - 1 - g;
		logic [SW-1:0] sub;
		logic [SW-1:0] remx;
		logic          take;

		assign sub  = SW'(den_sk[g]) << BIT;
		assign remx = SW'(rem_sk[g]);
		assign take = remx >= sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[g+1] <= 1'b0;
			end else if (en) begin
				vld_sk[g+1] <= vld_sk[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_sk[g+1] <= tag_sk[g];
				den_sk[g+1] <= den_sk[g];
				if (take) begin
					rem_sk[g+1] <= NUM_W'(remx - sub);
					quo_sk[g+1] <= quo_sk[g] | (Q_W'(1) << BIT);
				end else begin
					rem_sk[g+1] <= rem_sk[g];
					quo_sk[g+1] <= quo_sk[g];
				end
			end
		end
	end

	assign out_valid = vld_sk[Q_W];
	assign out_quot  = quo_sk[Q_W];
	assign out_tag   = tag_sk[Q_W];
endmodule

FILE: hw/rtl/differential_drive_mixer.sv
// Top level of the differential drive mixer: squares, root, two dividers, output.
//  channel | direction | tdata / payload                        | tuser
//  s_*     | in        | forward_cmd, turn_cmd                  | -
//  m_*     | out       | left_drive, right_drive                | -
//  cfg_*   | in        | cfg_index selects register, cfg_data   | -
// One command enters per cycle unless the output stalls; the path runs through the
// root pipeline (one bit per stage) and two 10-stage dividers.
// Reset returns enable to 0 and the limits to 180 and 250; the pipe is emptied.
// A stalled output freezes the whole pipe; nothing is lost or repeated.
// Commands taken while disabled are consumed without a result.
`timescale 1ns / 1ps
`include "differential_drive_mixer_assert.svh"
module differential_drive_mixer
	import ddm_pkg::*;
#(
	parameter int CMD_WIDTH = 11
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [CMD_WIDTH-1:0] forward_cmd, next CMD_WIDTH bits turn_cmd, zero pad
	input  logic [((2*CMD_WIDTH+7)/8)*8-1:0]      s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [10:0] left_drive, [21:11] right_drive, [23:22] zero
	output logic [23:0]                           m_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]                  cfg_index,
	input  logic [LIM_W-1:0]                      cfg_data
);
	localparam int W    = CMD_WIDTH;
	localparam int DW   = 2 * W;
	localparam int CW   = (W > LIM_W) ? W : LIM_W;

	typedef struct packed {
		logic          s_neg;
		logic          scale_left;
		logic          den_zero;
		logic [DW:0]   num;
		logic [DW-1:0] den;
	} sq_tag_t;

	typedef struct packed {
		logic             s_neg;
		logic             scale_left;
		logic             den_zero;
		logic             sc_neg;
		logic [LIM_W-1:0] pmag;
	} dv_tag_t;

	// configuration registers
	logic             enable_q;
	logic [LIM_W-1:0] mag_limit_q;
	logic [LIM_W-1:0] full_scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			mag_limit_q  <= MAG_LIMIT_RST;
			full_scale_q <= FULL_SCALE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLE:     enable_q     <= cfg_data[0];
				REG_MAG_LIMIT:  mag_limit_q  <= cfg_data;
				REG_FULL_SCALE: full_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: pipe moves when the output slot is free or drained
	logic en;
	logic m_valid_q;
	assign en       = !m_valid_q || m_tready;
	assign s_tready = en;

	// stage 1: squares
	logic signed [DW-1:0] fwd_x, trn_x;
	logic                 v_s1;
	logic signed [W-1:0]  fwd_s1, trn_s1;
	logic [DW-1:0]        fsq_s1, tsq_s1;

	assign fwd_x = {{W{s_tdata[W-1]}}, s_tdata[W-1:0]};
	assign trn_x = {{W{s_tdata[DW-1]}}, s_tdata[DW-1:W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid && enable_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fwd_s1 <= s_tdata[W-1:0];
			trn_s1 <= s_tdata[DW-1:W];
			fsq_s1 <= fwd_x * fwd_x;
			tsq_s1 <= trn_x * trn_x;
		end
	end

	// stage 2: sum, difference and side select
	logic    v_s2;
	sq_tag_t tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2.s_neg      <= fwd_s1 < 0;
			tag_s2.scale_left <= (fwd_s1 >= 0 && trn_s1 < 0) || (fwd_s1 < 0 && trn_s1 > 0);
			tag_s2.den_zero   <= (fwd_s1 == 0) && (trn_s1 == 0);
			tag_s2.num        <= {1'b0, fsq_s1} - {1'b0, tsq_s1};
			tag_s2.den        <= fsq_s1 + tsq_s1;
		end
	end

	// square root of the vector length squared
	logic            v_rt;
	logic [W-1:0]    root_rt;
	sq_tag_t         tag_rt;

	ddm_sqrt #(.IN_W(DW), .TAG_W($bits(sq_tag_t))) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s2), .in_rad(tag_s2.den), .in_tag(tag_s2),
		.out_valid(v_rt), .out_root(root_rt), .out_tag(tag_rt)
	);

	// stage 3: clamp and scale product
	logic [LIM_W-1:0]   lim;
	logic [CW-1:0]      root_x;
	logic [LIM_W-1:0]   mag;
	logic               v_s3;
	logic [2*LIM_W-1:0] prod_s3;
	sq_tag_t            tag_s3;

	assign lim    = (mag_limit_q == '0) ? LIM_W'(1) : mag_limit_q;
	assign root_x = CW'(root_rt);
	assign mag    = (root_x > CW'(lim)) ? lim : root_x[LIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_rt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= (2*LIM_W)'(mag) * (2*LIM_W)'(full_scale_q);
			tag_s3  <= tag_rt;
		end
	end

	// power = mag * full_scale / limit
	logic             v_d1;
	logic [LIM_W-1:0] pmag_d1;
	sq_tag_t          tag_d1;

	ddm_div #(.NUM_W(2*LIM_W), .DEN_W(LIM_W), .Q_W(LIM_W), .TAG_W($bits(sq_tag_t))) u_div_pwr (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s3), .in_num(prod_s3), .in_den(lim), .in_tag(tag_s3),
		.out_valid(v_d1), .out_quot(pmag_d1), .out_tag(tag_d1)
	);

	// stage 4: power times |s^2 - r^2|
	logic [DW:0]          num_abs;
	logic                 v_s4;
	logic [LIM_W+DW-1:0]  prod_s4;
	logic [DW-1:0]        den_s4;
	dv_tag_t              tag_s4;

	assign num_abs = tag_d1.num[DW] ? -tag_d1.num : tag_d1.num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4           <= (LIM_W+DW)'(pmag_d1) * (LIM_W+DW)'(num_abs[DW-1:0]);
			den_s4            <= tag_d1.den;
			tag_s4.s_neg      <= tag_d1.s_neg;
			tag_s4.scale_left <= tag_d1.scale_left;
			tag_s4.den_zero   <= tag_d1.den_zero;
			tag_s4.sc_neg     <= tag_d1.s_neg ^ tag_d1.num[DW];
			tag_s4.pmag       <= pmag_d1;
		end
	end

	// scaled wheel magnitude, truncated toward zero
	logic             v_d2;
	logic [LIM_W-1:0] quo_d2;
	dv_tag_t          tag_d2;

	ddm_div #(.NUM_W(LIM_W+DW), .DEN_W(DW), .Q_W(LIM_W), .TAG_W($bits(dv_tag_t))) u_div_scl (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s4), .in_num(prod_s4), .in_den(den_s4), .in_tag(tag_s4),
		.out_valid(v_d2), .out_quot(quo_d2), .out_tag(tag_d2)
	);

	// output stage: signs and wheel select
	logic signed [OUT_W-1:0] pwr, scl, left_nx, right_nx;
	logic signed [OUT_W-1:0] left_q, right_q;
	logic                    zero_q;

	assign pwr = tag_d2.s_neg  ? -OUT_W'(tag_d2.pmag) : OUT_W'(tag_d2.pmag);
	assign scl = tag_d2.sc_neg ? -OUT_W'(quo_d2)      : OUT_W'(quo_d2);

	always_comb begin
		left_nx  = pwr;
		right_nx = pwr;
		if (!tag_d2.den_zero) begin
			if (tag_d2.scale_left) begin
				left_nx = scl;
			end else begin
				right_nx = scl;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (en) begin
			m_valid_q <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			left_q  <= left_nx;
			right_q <= right_nx;
			zero_q  <= tag_d2.den_zero;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, right_q, left_q};

	// magnitudes for checking
	logic [OUT_W-1:0] left_mag, right_mag;
	assign left_mag  = left_q[OUT_W-1]  ? -left_q  : left_q;
	assign right_mag = right_q[OUT_W-1] ? -right_q : right_q;

	`DDM_ASSERT(a_zero_cmd_equal, m_valid_q && zero_q |-> left_q == right_q, "zero command gave unequal wheels")
	`DDM_ASSERT(a_left_in_range, m_valid_q |-> left_mag <= OUT_W'(full_scale_q), "left drive beyond full scale")
	`DDM_ASSERT(a_right_in_range, m_valid_q |-> right_mag <= OUT_W'(full_scale_q), "right drive beyond full scale")
	`DDM_ASSERT(a_enter_pipe, s_tvalid && s_tready && enable_q |=> v_s1, "accepted command did not enter pipe")
endmodule
